// ----- rtl/core/ljpf_pkg.sv -----
`timescale 1ns / 1ps
package ljpf_pkg;

	localparam int COORD_W   = 32;
	localparam int RESULT_W  = 48;
	localparam int POS_FRAC  = 20;
	localparam int MAG_W     = COORD_W + 1;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int D2_W      = 66;
	localparam int CFG_W     = 32;
	localparam int ADDR_W    = 3;

	localparam int S_W       = 88;
	localparam int S3_W      = 112;
	localparam int S6_W      = 160;
	localparam int EPS12_W   = 36;

	localparam int LIMB      = 32;
	localparam int A_LIMBS   = 7;
	localparam int B_LIMBS   = 4;
	localparam int MUL_A_W   = A_LIMBS * LIMB;
	localparam int MUL_B_W   = B_LIMBS * LIMB;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int ROW_W     = MUL_A_W + LIMB;
	localparam int PAIR_W    = ROW_W + LIMB;

	localparam int DIV_N_W   = 185;
	localparam int DIV_D_W   = D2_W;
	localparam int DIV_Q_W   = S_W;
	localparam int DIV_H_W   = DIV_N_W - DIV_Q_W;

	localparam int FORCE_SHIFT = 64 - POS_FRAC;
	localparam int SIG_SHIFT   = 56;
	localparam int FRAC_SHIFT  = 64;

	localparam logic [CFG_W-1:0]    CFG_RESET = 32'h0100_0000;
	localparam logic [RESULT_W-1:0] RES_MAX   = {1'b0, {(RESULT_W-1){1'b1}}};
	localparam logic [RESULT_W-1:0] RES_MIN   = {1'b1, {(RESULT_W-1){1'b0}}};

	typedef enum logic {
		REG_SIGMA      = 1'b0,
		REG_WELL_DEPTH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_i_x;
		logic signed [COORD_W-1:0] pos_i_y;
		logic signed [COORD_W-1:0] pos_i_z;
		logic signed [COORD_W-1:0] pos_j_x;
		logic signed [COORD_W-1:0] pos_j_y;
		logic signed [COORD_W-1:0] pos_j_z;
	} in_word_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] pair_energy;
		logic signed [RESULT_W-1:0] force_i_x;
		logic signed [RESULT_W-1:0] force_i_y;
		logic signed [RESULT_W-1:0] force_i_z;
		logic signed [RESULT_W-1:0] force_j_x;
		logic signed [RESULT_W-1:0] force_j_y;
		logic signed [RESULT_W-1:0] force_j_z;
		logic                       coincident;
		logic                       saturated;
	} out_word_t;

	typedef struct packed {
		logic                       vld;
		logic [2:0][MAG_W-1:0]      mag;
		logic [2:0]                 rneg;
		logic [D2_W-1:0]            d2;
		logic                       coinc;
		logic [S_W-1:0]             s;
		logic [S3_W-1:0]            s3;
		logic                       eneg;
		logic                       fneg;
		logic [RESULT_W-1:0]        energy;
		logic                       esat;
	} side_t;

endpackage

// ----- rtl/core/ljpf_mul.sv -----
`timescale 1ns / 1ps
module ljpf_mul import ljpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	input  side_t              side_in,
	output logic [MUL_P_W-1:0] p,
	output side_t              side_out
);

	logic [B_LIMBS-1:0][A_LIMBS-1:0][2*LIMB-1:0] pp_s1;
	logic [B_LIMBS-1:0][ROW_W-1:0]               ev, od;
	logic [B_LIMBS-1:0][ROW_W-1:0]               row_s2;
	logic [1:0][PAIR_W-1:0]                      pair_s3;
	logic [MUL_P_W-1:0]                          p_s4;
	side_t                                       side_s1, side_s2, side_s3, side_s4;

	// even and odd limb products do not overlap among themselves
	always_comb begin
		for (int r = 0; r < B_LIMBS; r++) begin
			ev[r] = '0;
			od[r] = '0;
			for (int j = 0; j < A_LIMBS; j++) begin
				if (j % 2 == 0) ev[r][j*LIMB +: 2*LIMB] = pp_s1[r][j];
				else            od[r][j*LIMB +: 2*LIMB] = pp_s1[r][j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
		end else if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < B_LIMBS; r++) begin
				for (int j = 0; j < A_LIMBS; j++) begin
					pp_s1[r][j] <= a[j*LIMB +: LIMB] * b[r*LIMB +: LIMB];
				end
				row_s2[r] <= ev[r] + od[r];
			end
			pair_s3[0] <= {{LIMB{1'b0}}, row_s2[0]} + {row_s2[1], {LIMB{1'b0}}};
			pair_s3[1] <= {{LIMB{1'b0}}, row_s2[2]} + {row_s2[3], {LIMB{1'b0}}};
			p_s4 <= {{(MUL_P_W-PAIR_W){1'b0}}, pair_s3[0]}
				+ {pair_s3[1][MUL_P_W-2*LIMB-1:0], {(2*LIMB){1'b0}}};
		end
	end

	assign p        = p_s4;
	assign side_out = side_s4;

endmodule

// ----- rtl/core/ljpf_div.sv -----
`timescale 1ns / 1ps
module ljpf_div import ljpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	input  side_t              side_in,
	output logic [DIV_Q_W-1:0] q,
	output logic               over,
	output side_t              side_out
);

	logic [DIV_D_W-1:0] rem_s  [0:DIV_Q_W];
	logic [DIV_Q_W-1:0] lq_s   [0:DIV_Q_W];
	logic [DIV_D_W-1:0] den_s  [0:DIV_Q_W];
	logic               over_s [0:DIV_Q_W];
	side_t              side_s [0:DIV_Q_W];

	// quotient at or above 2^DIV_Q_W is flagged up front
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[0] <= '0;
		end else if (en) begin
			side_s[0] <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num[DIV_Q_W +: DIV_D_W];
			lq_s[0]   <= num[DIV_Q_W-1:0];
			den_s[0]  <= den;
			over_s[0] <= num[DIV_N_W-1:DIV_Q_W] >= DIV_H_W'(den);
		end
	end

	for (genvar k = 1; k <= DIV_Q_W; k++) begin : g_step
		logic [DIV_D_W:0] trial;
		logic             ge;

		assign trial = {rem_s[k-1], lq_s[k-1][DIV_Q_W-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else if (en) begin
				side_s[k] <= side_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DIV_D_W'(trial - {1'b0, den_s[k-1]}) : trial[DIV_D_W-1:0];
				lq_s[k]   <= {lq_s[k-1][DIV_Q_W-2:0], ge};
				den_s[k]  <= den_s[k-1];
				over_s[k] <= over_s[k-1];
			end
		end
	end

	assign q        = lq_s[DIV_Q_W];
	assign over     = over_s[DIV_Q_W];
	assign side_out = side_s[DIV_Q_W];

endmodule

// ----- rtl/core/lennard_jones_pair_force.sv -----
`timescale 1ns / 1ps
// channel   | signals                              | word
// ----------+--------------------------------------+-----------------------
// input     | in_valid, in_stall, in_word          | in_word_t, six coords
// output    | out_valid, out_stall, out_word       | out_word_t, E, F_i, F_j
// config    | psel penable pwrite paddr pwdata ... | sigma, well_depth
//
// One word per cycle unless the output stalls; from acceptance to result the
// path runs through two 89-stage dividers, five 4-stage limb multipliers and
// ten single registers in series.
// Reset clears valid bits and loads both registers with 1.0.
// A stalled output word freezes the whole pipeline; nothing is dropped.
module lennard_jones_pair_force import ljpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_word_t          in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output out_word_t         out_word,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]  prdata,
	output logic              pready
);

	logic [CFG_W-1:0]   sigma_q, well_q;
	logic [EPS12_W-1:0] eps12_q;
	logic               en;
	logic               out_vld_q;
	out_word_t          out_word_q;
	out_word_t          out_word_nx;

	logic [2:0][COORD_W-1:0] pi, pj;
	logic [2:0][MAG_W-1:0]   d;
	side_t                   side_in1;

	side_t                   side_s1, side_s2, side_s3, side_s4, side_s5;
	side_t                   side_s6, side_s7, side_s8, side_s9;
	side_t                   nx_s3, nx_s4, nx_s5, nx_s7, nx_s8;
	logic [2:0][SQ_W-1:0]    sq_s2;
	logic [2*CFG_W-1:0]      sig2_s2, sig2_s3;
	logic [S6_W+1:0]         de_s6;
	logic [S6_W:0]           df_s6;
	logic [S6_W:0]           et_s7;
	logic [S6_W-1:0]         ft_s7;
	logic [MUL_A_W-1:0]      prod_s8;
	logic [2:0][RESULT_W-1:0] fi_s9;
	logic [2:0]              fsat_s9;

	side_t                   div1_in, div1_side, sq_side, cube_side, s6_side, en_side;
	logic [DIV_Q_W-1:0]      div1_q;
	logic                    div1_over;
	logic [MUL_P_W-1:0]      p_sq, p_cube, p_s6, p_en, p_fm;
	logic [MUL_P_W-FRAC_SHIFT-1:0] emag;
	logic [2:0][MUL_P_W-1:0] p_f;
	side_t                   f_mside [3];
	side_t                   f_dside [3];
	logic [2:0][DIV_Q_W-1:0] f_q;
	logic [2:0]              f_over;

	assign en        = !(out_vld_q && out_stall);
	assign in_stall  = !en;
	assign out_valid = out_vld_q;
	assign out_word  = out_word_q;
	assign pready    = 1'b1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= CFG_RESET;
			well_q  <= CFG_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_SIGMA:      sigma_q <= pwdata;
				REG_WELL_DEPTH: well_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_SIGMA:      prdata = sigma_q;
			REG_WELL_DEPTH: prdata = well_q;
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		eps12_q <= {1'b0, well_q, 3'b000} + {2'b00, well_q, 2'b00};
	end

	// separation
	always_comb begin
		pi = {in_word.pos_i_x, in_word.pos_i_y, in_word.pos_i_z};
		pj = {in_word.pos_j_x, in_word.pos_j_y, in_word.pos_j_z};
		side_in1 = '0;
		side_in1.vld = in_valid;
		for (int c = 0; c < 3; c++) begin
			d[c] = {pi[2-c][COORD_W-1], pi[2-c]} - {pj[2-c][COORD_W-1], pj[2-c]};
			side_in1.rneg[c] = d[c][MAG_W-1];
			side_in1.mag[c]  = d[c][MAG_W-1] ? MAG_W'(-d[c]) : d[c];
		end
	end

	always_comb begin
		nx_s3    = side_s2;
		nx_s3.d2 = D2_W'(sq_s2[0]) + D2_W'(sq_s2[1]) + D2_W'(sq_s2[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
		end else if (en) begin
			side_s1 <= side_in1;
			side_s2 <= side_s1;
			side_s3 <= nx_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) sq_s2[c] <= side_s1.mag[c] * side_s1.mag[c];
			sig2_s2 <= sigma_q * sigma_q;
			sig2_s3 <= sig2_s2;
		end
	end

	always_comb begin
		div1_in       = side_s3;
		div1_in.coinc = side_s3.d2 == '0;
	end

	// s = sigma^2 / d2
	ljpf_div u_div_s (
		.clk, .arst_n, .en,
		.num      (DIV_N_W'({sig2_s3, {SIG_SHIFT{1'b0}}})),
		.den      (side_s3.d2),
		.side_in  (div1_in),
		.q        (div1_q),
		.over     (div1_over),
		.side_out (div1_side)
	);

	always_comb begin
		nx_s4   = div1_side;
		nx_s4.s = div1_over ? {S_W{1'b1}} : div1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else if (en) begin
			side_s4 <= nx_s4;
		end
	end

	ljpf_mul u_mul_sq (
		.clk, .arst_n, .en,
		.a (MUL_A_W'(side_s4.s)), .b (MUL_B_W'(side_s4.s)),
		.side_in (side_s4), .p (p_sq), .side_out (sq_side)
	);

	ljpf_mul u_mul_cube (
		.clk, .arst_n, .en,
		.a (MUL_A_W'(p_sq[FRAC_SHIFT +: S3_W])), .b (MUL_B_W'(sq_side.s)),
		.side_in (sq_side), .p (p_cube), .side_out (cube_side)
	);

	always_comb begin
		nx_s5    = cube_side;
		nx_s5.s3 = (|p_cube[MUL_P_W-1:FRAC_SHIFT+S3_W]) ? {S3_W{1'b1}}
			: p_cube[FRAC_SHIFT +: S3_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else if (en) begin
			side_s5 <= nx_s5;
		end
	end

	ljpf_mul u_mul_s6 (
		.clk, .arst_n, .en,
		.a (MUL_A_W'(side_s5.s3)), .b (MUL_B_W'(side_s5.s3)),
		.side_in (side_s5), .p (p_s6), .side_out (s6_side)
	);

	// s6 - 2 s3 and s6 - s3, then magnitudes
	always_comb begin
		nx_s7      = side_s6;
		nx_s7.eneg = de_s6[S6_W+1];
		nx_s7.fneg = df_s6[S6_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s6 <= '0;
			side_s7 <= '0;
		end else if (en) begin
			side_s6 <= s6_side;
			side_s7 <= nx_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			de_s6 <= {2'b00, p_s6[FRAC_SHIFT +: S6_W]} - (S6_W+2)'({s6_side.s3, 1'b0});
			df_s6 <= {1'b0, p_s6[FRAC_SHIFT +: S6_W]} - (S6_W+1)'(s6_side.s3);
			et_s7 <= de_s6[S6_W+1] ? (S6_W+1)'(-de_s6) : de_s6[S6_W:0];
			ft_s7 <= df_s6[S6_W] ? S6_W'(-df_s6) : df_s6[S6_W-1:0];
		end
	end

	ljpf_mul u_mul_en (
		.clk, .arst_n, .en,
		.a (MUL_A_W'(et_s7)), .b (MUL_B_W'(well_q)),
		.side_in (side_s7), .p (p_en), .side_out (en_side)
	);

	ljpf_mul u_mul_fm (
		.clk, .arst_n, .en,
		.a (MUL_A_W'(ft_s7)), .b (MUL_B_W'(eps12_q)),
		.side_in (side_s7), .p (p_fm), .side_out ()
	);

	assign emag = p_en[MUL_P_W-1:FRAC_SHIFT];

	// energy clip
	always_comb begin
		nx_s8 = en_side;
		if (!en_side.eneg) begin
			nx_s8.esat   = |emag[$bits(emag)-1:RESULT_W-1];
			nx_s8.energy = (|emag[$bits(emag)-1:RESULT_W-1]) ? RES_MAX
				: emag[RESULT_W-1:0];
		end else if ((|emag[$bits(emag)-1:RESULT_W])
			|| (emag[RESULT_W-1] && |emag[RESULT_W-2:0])) begin
			nx_s8.esat   = 1'b1;
			nx_s8.energy = RES_MIN;
		end else begin
			nx_s8.esat   = 1'b0;
			nx_s8.energy = RESULT_W'(-emag[RESULT_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s8 <= '0;
		end else if (en) begin
			side_s8 <= nx_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) prod_s8 <= p_fm[MUL_A_W-1:0];
	end

	// force lanes
	for (genvar c = 0; c < 3; c++) begin : g_lane
		ljpf_mul u_mul_f (
			.clk, .arst_n, .en,
			.a (prod_s8), .b (MUL_B_W'(side_s8.mag[c])),
			.side_in (side_s8), .p (p_f[c]), .side_out (f_mside[c])
		);

		ljpf_div u_div_f (
			.clk, .arst_n, .en,
			.num      (p_f[c][FORCE_SHIFT +: DIV_N_W]),
			.den      (f_mside[c].d2),
			.side_in  (f_mside[c]),
			.q        (f_q[c]),
			.over     (f_over[c]),
			.side_out (f_dside[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s9 <= '0;
		end else if (en) begin
			side_s9 <= f_dside[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				if (!(f_dside[0].fneg ^ f_dside[0].rneg[c])) begin
					fsat_s9[c] <= f_over[c] || (|f_q[c][DIV_Q_W-1:RESULT_W-1]);
					fi_s9[c]   <= (f_over[c] || (|f_q[c][DIV_Q_W-1:RESULT_W-1])) ? RES_MAX
						: f_q[c][RESULT_W-1:0];
				end else if (f_over[c] || (|f_q[c][DIV_Q_W-1:RESULT_W])
					|| (f_q[c][RESULT_W-1] && |f_q[c][RESULT_W-2:0])) begin
					fsat_s9[c] <= 1'b1;
					fi_s9[c]   <= RES_MIN;
				end else begin
					fsat_s9[c] <= 1'b0;
					fi_s9[c]   <= RESULT_W'(-f_q[c][RESULT_W-1:0]);
				end
			end
		end
	end

	// output word
	always_comb begin
		if (side_s9.coinc) begin
			out_word_nx            = '0;
			out_word_nx.coincident = 1'b1;
		end else begin
			out_word_nx.pair_energy = side_s9.energy;
			out_word_nx.force_i_x   = fi_s9[0];
			out_word_nx.force_i_y   = fi_s9[1];
			out_word_nx.force_i_z   = fi_s9[2];
			out_word_nx.force_j_x   = (fi_s9[0] == RES_MIN) ? RES_MAX : RESULT_W'(-fi_s9[0]);
			out_word_nx.force_j_y   = (fi_s9[1] == RES_MIN) ? RES_MAX : RESULT_W'(-fi_s9[1]);
			out_word_nx.force_j_z   = (fi_s9[2] == RES_MIN) ? RES_MAX : RESULT_W'(-fi_s9[2]);
			out_word_nx.coincident  = 1'b0;
			out_word_nx.saturated   = side_s9.esat || (|fsat_s9)
				|| (fi_s9[0] == RES_MIN) || (fi_s9[1] == RES_MIN)
				|| (fi_s9[2] == RES_MIN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= side_s9.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_word_q <= out_word_nx;
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb import ljpf_pkg::*;;

	typedef logic [319:0] wide_t;

	class pair_force_board;
		out_word_t pending_q[$];
		int        errors;
		logic [CFG_W-1:0] sigma_q;
		logic [CFG_W-1:0] depth_q;

		function new();
			errors  = 0;
			sigma_q = CFG_RESET;
			depth_q = CFG_RESET;
		endfunction

		function automatic logic [RESULT_W-1:0] clamp(wide_t m, bit neg, inout bit sat);
			wide_t lim;
			lim = wide_t'(RES_MAX);
			if (!neg) begin
				if (m > lim) begin
					sat = 1;
					return RES_MAX;
				end
				return m[RESULT_W-1:0];
			end
			lim = lim + 1;
			if (m > lim) begin
				sat = 1;
				return RES_MIN;
			end
			return -m[RESULT_W-1:0];
		endfunction

		function automatic out_word_t lj_force(in_word_t w);
			longint     ci[3], cj[3], d;
			wide_t      mag[3];
			bit         rn[3];
			wide_t      d2, s, t, s3, s6, diff, prod, den, q, cap;
			bit         sat, eneg, fneg;
			logic [RESULT_W-1:0] fi[3], fj[3];
			out_word_t  o;
			ci[0] = longint'(w.pos_i_x); ci[1] = longint'(w.pos_i_y); ci[2] = longint'(w.pos_i_z);
			cj[0] = longint'(w.pos_j_x); cj[1] = longint'(w.pos_j_y); cj[2] = longint'(w.pos_j_z);
			o   = '0;
			sat = 0;
			d2  = '0;
			for (int c = 0; c < 3; c++) begin
				d      = ci[c] - cj[c];
				rn[c]  = d < 0;
				mag[c] = wide_t'(rn[c] ? -d : d);
				d2     = d2 + mag[c] * mag[c];
			end
			if (d2 == 0) begin
				o.coincident = 1;
				return o;
			end
			s   = ((wide_t'(sigma_q) * wide_t'(sigma_q)) << SIG_SHIFT) / d2;
			cap = (wide_t'(1) << S_W) - 1;
			if (s > cap) s = cap;
			t  = (s * s) >> FRAC_SHIFT;
			s3 = (t * s) >> FRAC_SHIFT;
			cap = (wide_t'(1) << S3_W) - 1;
			if (s3 > cap) s3 = cap;
			s6 = (s3 * s3) >> FRAC_SHIFT;
			t    = s3 + s3;
			eneg = t > s6;
			diff = eneg ? t - s6 : s6 - t;
			prod = (wide_t'(depth_q) * diff) >> FRAC_SHIFT;
			o.pair_energy = clamp(prod, eneg, sat);
			fneg = s3 > s6;
			diff = fneg ? s3 - s6 : s6 - s3;
			prod = wide_t'(12) * wide_t'(depth_q) * diff;
			den  = d2 << FORCE_SHIFT;
			for (int c = 0; c < 3; c++) begin
				q     = (prod * mag[c]) / den;
				fi[c] = clamp(q, fneg ^ rn[c], sat);
				if (fi[c] == RES_MIN) begin
					fj[c] = RES_MAX;
					sat   = 1;
				end else begin
					fj[c] = -fi[c];
				end
			end
			o.force_i_x = fi[0]; o.force_i_y = fi[1]; o.force_i_z = fi[2];
			o.force_j_x = fj[0]; o.force_j_y = fj[1]; o.force_j_z = fj[2];
			o.saturated = sat;
			return o;
		endfunction

		function void note_pair(in_word_t w);
			pending_q.push_back(lj_force(w));
		endfunction

		task report(string what, logic [RESULT_W-1:0] got, logic [RESULT_W-1:0] want);
			$display("%0t: %s got %h want %h", $time, what, got, want);
			errors++;
		endtask

		task check_word(out_word_t got);
			out_word_t want;
			if (pending_q.size() == 0) begin
				report("unexpected word", '0, '0);
				return;
			end
			want = pending_q.pop_front();
			if (got.pair_energy !== want.pair_energy) report("pair_energy", got.pair_energy, want.pair_energy);
			if (got.force_i_x !== want.force_i_x) report("force_i_x", got.force_i_x, want.force_i_x);
			if (got.force_i_y !== want.force_i_y) report("force_i_y", got.force_i_y, want.force_i_y);
			if (got.force_i_z !== want.force_i_z) report("force_i_z", got.force_i_z, want.force_i_z);
			if (got.force_j_x !== want.force_j_x) report("force_j_x", got.force_j_x, want.force_j_x);
			if (got.force_j_y !== want.force_j_y) report("force_j_y", got.force_j_y, want.force_j_y);
			if (got.force_j_z !== want.force_j_z) report("force_j_z", got.force_j_z, want.force_j_z);
			if (got.coincident !== want.coincident) report("coincident", got.coincident, want.coincident);
			if (got.saturated !== want.saturated) report("saturated", got.saturated, want.saturated);
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_word_t          in_word;
	logic              out_valid;
	logic              out_stall;
	out_word_t         out_word;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [CFG_W-1:0]  pwdata;
	logic [CFG_W-1:0]  prdata;
	logic              pready;

	pair_force_board board = new();
	int  hold_req  = 0;
	int  hold_seen = 0;
	bit  no_gaps   = 0;

	lennard_jones_pair_force dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall) board.note_pair(in_word);
		if (out_valid && !out_stall) board.check_word(out_word);
	end

	// receiver: random stalls, plus an occasional long hold-off on request
	initial begin
		int k;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
			end
			k = $urandom_range(0, 15);
			if (k < 10) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else if (k < 15) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	task cfg_write(reg_idx_t idx, logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_SIGMA) board.sigma_q = value;
		else board.depth_q = value;
	endtask

	task send_word(in_word_t w);
		int k, gap;
		k   = $urandom_range(0, 15);
		gap = no_gaps ? 0 : (k < 10 ? 0 : (k < 14 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic in_word_t near_pair();
		logic signed [COORD_W-1:0] a[3], b[3], dl;
		in_word_t w;
		int m;
		for (int c = 0; c < 3; c++) begin
			a[c] = $urandom;
			m    = $urandom_range(0, 9);
			if (m == 0) b[c] = $urandom;
			else if (m == 1) b[c] = a[c];
			else begin
				dl   = $signed($urandom) >>> $urandom_range(6, 31);
				b[c] = a[c] - dl;
			end
		end
		w.pos_i_x = a[0]; w.pos_i_y = a[1]; w.pos_i_z = a[2];
		w.pos_j_x = b[0]; w.pos_j_y = b[1]; w.pos_j_z = b[2];
		return w;
	endfunction

	function automatic in_word_t mk(int ix, int iy, int iz, int jx, int jy, int jz);
		in_word_t w;
		w.pos_i_x = ix; w.pos_i_y = iy; w.pos_i_z = iz;
		w.pos_j_x = jx; w.pos_j_y = jy; w.pos_j_z = jz;
		return w;
	endfunction

	initial begin
		logic [CFG_W-1:0] sig_set[6], dep_set[6];
		int one, mx, mn;
		one = 1 << POS_FRAC;
		mx  = 32'h7fff_ffff;
		mn  = 32'h8000_0000;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_word  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings
		send_word(mk(5, 5, 5, 5, 5, 5));
		send_word(mk(0, 0, 0, 0, 0, 0));
		send_word(mk(mn, mn, mn, mn, mn, mn));
		send_word(mk(mx, mx, mx, mn, mn, mn));
		send_word(mk(mn, mn, mn, mx, mx, mx));
		send_word(mk(mx, 0, 0, mn, 0, 0));
		send_word(mk(one, 0, 0, 0, 0, 0));
		send_word(mk(0, -one, 0, 0, 0, 0));
		send_word(mk(0, 0, 0, 0, 0, one));
		send_word(mk(1, 0, 0, 0, 0, 0));
		send_word(mk(0, 0, 0, 1, 1, 1));
		send_word(mk(one + one / 8, 0, 0, 0, 0, 0));
		send_word(mk(2 * one, one, -one, 0, 0, 0));
		send_word(mk(one / 2, one / 2, 0, 0, 0, 0));
		send_word(mk(100 * one, 0, 0, -100 * one, 0, 0));
		send_word(mk(7, -3, 9, 7, -3, 9));
		drain();

		sig_set[0] = CFG_RESET;     dep_set[0] = CFG_RESET;
		sig_set[1] = 32'h0;         dep_set[1] = 32'hffff_ffff;
		sig_set[2] = 32'hffff_ffff; dep_set[2] = 32'h0;
		sig_set[3] = 32'hffff_ffff; dep_set[3] = 32'hffff_ffff;
		sig_set[4] = $urandom;      dep_set[4] = $urandom;
		sig_set[5] = 32'h0000_4000; dep_set[5] = 32'h0000_0001;
		for (int p = 0; p < 6; p++) begin
			cfg_write(REG_SIGMA, sig_set[p]);
			cfg_write(REG_WELL_DEPTH, dep_set[p]);
			no_gaps = (p == 3);
			for (int n = 0; n < 180; n++) begin
				if (p == 0 && n == 20) hold_req++;
				send_word(near_pair());
			end
			// sender waits for every outstanding word before reconfiguring
			drain();
		end

		repeat (300) @(posedge clk);
		if (board.errors == 0 && board.pending_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ljpf_pkg.sv
rtl/core/ljpf_mul.sv
rtl/core/ljpf_div.sv
rtl/core/lennard_jones_pair_force.sv
dv/tb.sv
